[sv/tccw_pkg.sv]
// package for the text console character writer
// holds the command record, kind codes, character constants and result packing
// used by the top, front end and back end of the console; depends on nothing
`default_nettype none

package tccw_pkg;

    // character and attribute constants
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'hF5;

    // what the back end does with a command
    localparam logic [1:0] KIND_NOP   = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic [1:0] kind;
        logic       scroll;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [7:0] fill_attr;
        logic [6:0] col;
        logic [4:0] row;
    } cmd_t;

    // result word: char, attr, col, row, scrolled from the lowest bit up
    function automatic logic [31:0] pack_result(cmd_t c, logic [7:0] ch, logic [7:0] attr);
        pack_result = {3'b000, c.scroll, c.row, c.col, attr, ch};
    endfunction

endpackage

`default_nettype wire

[sv/text_console_char_writer.sv]
// Text console character writer: a ROWS x COLUMNS store of character and
// attribute cells with a cursor. After reset the store is swept to blanks in
// attribute F5, one cell per cycle, all ROWS*COLUMNS cells (2000 by default),
// with s_tready low; the attribute register may be written meanwhile. The
// front end accepts one item per cycle into a QUEUE_DEPTH command queue while
// there is room. The back end drains it through the single-port-write,
// registered-read cell store, one item at a time; a put or newline that
// scrolls rewrites the whole store, since each of the (ROWS-1)*COLUMNS moved
// cells and each of the COLUMNS blank cells is one store write. One result
// comes out per item, in order.
// depends on tccw_pkg, tccw_front, tccw_queue, tccw_back
`default_nettype none

module text_console_char_writer #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // fields from lowest bit: char_code[7:0], cell_index[18:8], zero[23:19]
    input  wire logic [23:0] s_tdata,
    // fields from lowest bit: op[0]
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // fields from lowest bit: cell_char[7:0], cell_attr[15:8],
    // cursor_col[22:16], cursor_row[27:23], scrolled[28], zero[31:29]
    output logic [31:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    import tccw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int QW    = $bits(cmd_t) + AW;

    logic          clearing;
    logic          q_full;
    logic          q_wr_en;
    cmd_t          f_cmd;
    logic [AW-1:0] f_addr;
    logic          q_valid;
    logic          q_rd_en;
    logic [QW-1:0] q_rd_data;
    cmd_t          b_cmd;
    logic [AW-1:0] b_addr;

    assign b_cmd  = q_rd_data[QW-1:AW];
    assign b_addr = q_rd_data[AW-1:0];

    // item intake and classification
    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_wr_en     (q_wr_en),
        .q_cmd       (f_cmd),
        .q_addr      (f_addr)
    );

    // command queue
    tccw_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  ({f_cmd, f_addr}),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_data)
    );

    // store execution and result register
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rd_en  (q_rd_en),
        .q_cmd    (b_cmd),
        .q_addr   (b_addr),
        .clearing (clearing),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

`default_nettype wire

[sv/tccw_queue.sv]
// small command queue between the console front end and back end
// register-based fifo with a fill count; no package dependencies
`default_nettype none

module tccw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == NW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[sv/tccw_front.sv]
// console front end: accepts items, keeps cursor and attribute, classifies
// each item into a command for the back end; depends on tccw_pkg
`default_nettype none

module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // fields from lowest bit: char_code[7:0], cell_index[18:8]
    input  wire logic [23:0]   s_tdata,
    // fields from lowest bit: op[0]
    input  wire logic          s_tuser,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          clearing,
    input  wire logic          q_full,
    output logic               q_wr_en,
    output tccw_pkg::cmd_t     q_cmd,
    output logic [AW-1:0]      q_addr
);

    import tccw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW    = $clog2(ROWS);

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [7:0]    attr_reg;
    logic          accept;
    logic          op_read;
    logic [7:0]    char_code;
    logic [10:0]   cell_index;
    logic [31:0]   index_ext;
    logic [31:0]   pos_ext;
    logic [31:0]   col_ext;
    logic [31:0]   row_ext;
    logic          last_row;
    logic          last_col;

    assign s_tready   = !clearing && !q_full;
    assign accept     = s_tvalid && s_tready;
    assign op_read    = s_tuser;
    assign char_code  = s_tdata[7:0];
    assign cell_index = s_tdata[18:8];
    assign index_ext  = 32'(cell_index);
    assign pos_ext    = 32'(row_reg) * COLUMNS + 32'(col_reg);
    assign last_row   = (row_reg == RW'(ROWS - 1));
    assign last_col   = (col_reg == CW'(COLUMNS - 1));
    assign col_ext    = 32'(col_next);
    assign row_ext    = 32'(row_next);

    // classify the item and work out the cursor after it
    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        q_cmd.kind      = KIND_NOP;
        q_cmd.scroll    = 1'b0;
        q_cmd.ch        = 8'h00;
        q_cmd.attr      = 8'h00;
        q_cmd.fill_attr = attr_reg;
        q_addr          = pos_ext[AW-1:0];
        if (op_read)
        begin
            q_addr = index_ext[AW-1:0];
            if (index_ext < 32'(CELLS))
            begin
                q_cmd.kind = KIND_READ;
            end
        end
        else
        begin
            if (char_code != NEWLINE_CODE)
            begin
                q_cmd.kind = KIND_WRITE;
                q_cmd.ch   = char_code;
                q_cmd.attr = attr_reg;
                col_next   = col_reg + 1'b1;
            end
            // newline, or wrap after the last column
            if (char_code == NEWLINE_CODE || last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    q_cmd.scroll = 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
        end
        q_cmd.col = col_ext[6:0];
        q_cmd.row = row_ext[4:0];
    end

    assign q_wr_en = accept;

    // cursor and attribute registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            attr_reg <= RESET_ATTR;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

[sv/tccw_back.sv]
// console back end: owns the cell store, runs the clearing pass, writes,
// reads and scrolls, and holds the result register; depends on tccw_pkg
`default_nettype none

module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_rd_en,
    input  wire tccw_pkg::cmd_t q_cmd,
    input  wire logic [AW-1:0] q_addr,
    output logic               clearing,
    // fields from lowest bit: cell_char[7:0], cell_attr[15:8],
    // cursor_col[22:16], cursor_row[27:23], scrolled[28], zero[31:29]
    output logic [31:0]        m_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready
);

    import tccw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

    logic [15:0]   mem [CELLS];
    logic [15:0]   rd_reg;
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    cmd_t          cur_reg;
    cmd_t          cur_next;
    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;
    logic          slot_free;
    logic          out_load;
    logic [31:0]   out_word;
    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          re;
    logic [AW-1:0] ra;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign clearing  = (state_reg == ST_CLEAR);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        q_rd_en    = 1'b0;
        out_load   = 1'b0;
        out_word   = pack_result(cur_reg, cur_reg.ch, cur_reg.attr);
        we         = 1'b0;
        wa         = cnt_reg;
        wd         = {RESET_ATTR, BLANK_CHAR};
        re         = 1'b0;
        ra         = q_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_rd_en  = 1'b1;
                    cur_next = q_cmd;
                    out_word = pack_result(q_cmd, q_cmd.ch, q_cmd.attr);
                    cnt_next = '0;
                    if (q_cmd.kind == KIND_READ)
                    begin
                        re         = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        if (q_cmd.kind == KIND_WRITE)
                        begin
                            we = 1'b1;
                            wa = q_addr;
                            wd = {q_cmd.attr, q_cmd.ch};
                        end
                        if (q_cmd.scroll)
                        begin
                            state_next = ST_COPY;
                        end
                        else
                        begin
                            out_load = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                out_word   = pack_result(cur_reg, rd_reg[7:0], rd_reg[15:8]);
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                // read one row down, write what came back in the following cycle
                ra = cnt_reg + ROW_STEP;
                re = (cnt_reg < COPY_END);
                we = (cnt_reg != '0);
                wa = cnt_reg - 1'b1;
                wd = rd_reg;
                if (cnt_reg == COPY_END)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                we = 1'b1;
                wd = {cur_reg.fill_attr, BLANK_CHAR};
                if (cnt_reg == LAST_CELL)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (out_load)
        begin
            m_tdata_reg <= out_word;
        end
    end

    // cell store with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    // no command leaves the queue unless the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_rd_en |-> (state_reg == ST_IDLE && q_valid))
        else $error("command popped while back end busy");

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result loaded over a pending transfer");

    // a scrolling command reports only after the blank row is filled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg != ST_IDLE && cur_reg.scroll) |-> (state_reg == ST_FILL))
        else $error("scroll result before fill finished");

    // copy writes always trail the reads of the row below
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && re && we) |-> (wa < ra))
        else $error("scroll copy overtook its source");

endmodule

`default_nettype wire

[sim/console_cell_check.sv]
// result checker for the text console character writer plus the opcode package
// of the testbench; mirrors cell store, cursor and attribute, compares results
// depends on tccw_pkg
package console_tb_pkg;

    // screen geometry of the default build
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // item kinds carried on s_tuser
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

module console_cell_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;
    import console_tb_pkg::*;

    // result word, cell_char in the lowest bits
    typedef struct packed {
        logic       scrolled;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] attr;
        logic [7:0] ch;
    } console_result_t;

    // mirror of the console: attribute in the high byte of each cell
    logic [15:0]     screen [CELLS];
    int              cur_col;
    int              cur_row;
    logic [7:0]      attr_reg;
    console_result_t expected_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // cursor to the start of the next row, scrolling at the bottom
    function automatic logic advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = {attr_reg, BLANK_CHAR};
            cur_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one item to the mirror and work out its result
    function automatic console_result_t apply_item(logic op, logic [7:0] code,
                                                   logic [10:0] index);
        console_result_t r;
        r = '0;
        if (op == OP_READ)
        begin
            if (index < CELLS)
            begin
                r.ch   = screen[index][7:0];
                r.attr = screen[index][15:8];
            end
        end
        else if (code == NEWLINE_CODE)
        begin
            r.scrolled = advance_row();
        end
        else
        begin
            screen[cur_row * COLUMNS + cur_col] = {attr_reg, code};
            r.ch   = code;
            r.attr = attr_reg;
            cur_col++;
            if (cur_col >= COLUMNS)
                r.scrolled = advance_row();
        end
        r.col = cur_col[6:0];
        r.row = cur_row[4:0];
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // watch register writes and both transfer channels
    always @(posedge clk)
    begin
        console_result_t want;
        console_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = {RESET_ATTR, BLANK_CHAR};
            cur_col  = 0;
            cur_row  = 0;
            attr_reg = RESET_ATTR;
            expected_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                attr_reg = cfg_wr_data;

            // result transfer against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[28:0];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result %h with nothing outstanding", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("cell_char", want.ch, got.ch);
                    check_field("cell_attr", want.attr, got.attr);
                    check_field("cursor_col", want.col, got.col);
                    check_field("cursor_row", want.row, got.row);
                    check_field("scrolled", want.scrolled, got.scrolled);
                    check_field("pad bits", 0, m_tdata[31:29]);
                end
            end

            // input transfer
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_item(s_tuser, s_tdata[7:0], s_tdata[18:8]));
        end
        pending = expected_q.size();
    end

endmodule

[sim/tb.sv]
// top of the text console character writer testbench: clock, reset, stimulus,
// register writes and the verdict
// depends on tccw_pkg, console_tb_pkg, console_cell_check and the console RTL
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;
    import console_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    int          errors;
    int          pending;

    // sender pacing
    int          burst_left;
    bit          no_gaps;

    // receiver stall pattern
    int          stall_mode = 0;
    int          stall_tick = 0;

    text_console_char_writer u_dut (.*);

    console_cell_check u_check (.*);

    always #1 clk = ~clk;

    // receiver: m_tready follows a stall mode that is re-picked at random
    always @(negedge clk)
    begin
        if (stall_tick % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= stall_tick[3];
        endcase
    end

    // hold one item until it transfers, then maybe end the burst with a gap
    task automatic send_item(logic op, logic [7:0] code, logic [10:0] index);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, index, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 6))
                    @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
    endtask

    task automatic write_attr(logic [7:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random text with reads mixed in, in a shape picked per phase
    task automatic run_phase(int count);
        int          read_pct;
        int          nl_pct;
        int          pick;
        logic [10:0] index;
        logic [7:0]  code;
        case ($urandom_range(0, 2))
            0:       read_pct = 10;
            1:       read_pct = 35;
            default: read_pct = 60;
        endcase
        case ($urandom_range(0, 2))
            0:       nl_pct = 0;
            1:       nl_pct = 4;
            default: nl_pct = 12;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < read_pct)
            begin
                pick = $urandom_range(0, 9);
                // out of range, bottom two rows, or anywhere on screen
                if (pick == 0)
                    index = 11'($urandom_range(CELLS, 2047));
                else if (pick < 4)
                    index = 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
                else
                    index = 11'($urandom_range(0, CELLS - 1));
                send_item(OP_READ, 8'($urandom), index);
            end
            else
            begin
                code = ($urandom_range(0, 99) < nl_pct) ? NEWLINE_CODE : 8'($urandom);
                send_item(OP_PUT, code, 11'($urandom));
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        burst_left  = 0;
        no_gaps     = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, out-of-range reads, extreme bytes, newline
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'hFF, 11'(CELLS - 1));
        send_item(OP_READ, 8'h00, 11'(CELLS));
        send_item(OP_READ, 8'h00, 11'h7FF);
        send_item(OP_PUT, 8'h00, 11'h7FF);
        send_item(OP_PUT, 8'hFF, 11'h000);
        send_item(OP_PUT, NEWLINE_CODE, 11'h000);
        send_item(OP_PUT, 8'h41, 11'h000);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_READ, 8'h00, 11'(COLUMNS));
        drain();

        // attribute at its low extreme
        write_attr(8'h00);
        send_item(OP_PUT, 8'h55, 11'h000);
        send_item(OP_PUT, 8'hAA, 11'h000);
        send_item(OP_READ, 8'h00, 11'(COLUMNS + 1));
        send_item(OP_READ, 8'h00, 11'(COLUMNS + 2));
        drain();

        // random phases, each under its own attribute
        for (int p = 0; p < 8; p++)
        begin
            write_attr(p == 0 ? 8'hFF : p == 1 ? 8'h00 : 8'($urandom));
            run_phase(155);
            drain();
        end

        repeat (20)
            @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
